@@ rtl/core/qap_pkg.sv @@
// Shared types and constants for the QAP cost evaluator.
`timescale 1ns / 1ps

package qap_pkg;

  // Item kinds
  localparam logic [1:0] KIND_FLOW    = 2'd0;
  localparam logic [1:0] KIND_DIST    = 2'd1;
  localparam logic [1:0] KIND_PERM    = 2'd2;
  localparam logic [1:0] KIND_COMPUTE = 2'd3;

  // Field widths fixed by the interface
  localparam int COST_W  = 48;
  localparam int SIZE_W  = 6;
  localparam int INDEX_W = 5;
  localparam int ENTRY_W = 16;

  // Permutation entries are kept saturated, wide enough to flag any value above n
  localparam int PERM_W = 7;
  localparam logic [PERM_W-1:0] PERM_SAT = {PERM_W{1'b1}};

  // Reset value of problem_size
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  // Configuration register map
  localparam logic REG_PROBLEM_SIZE = 1'b0;

  // Drain counter covering the datapath from pair issue to accumulator update
  localparam int DRAIN_W = 2;
  localparam logic [DRAIN_W-1:0] DRAIN_LAST = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic step;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_pair;
    logic size_zero;
  } sts_t;

endpackage

@@ rtl/core/qap_ctrl.sv @@
// Sequencer for the QAP cost evaluator: issue pairs, drain, strobe result.
`timescale 1ns / 1ps

module qap_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start_compute,
  input  qap_pkg::sts_t sts,
  output qap_pkg::cmd_t cmd,
  output logic          busy,
  output logic          result_valid
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                   state, state_next;
  logic [qap_pkg::DRAIN_W-1:0]  drain_cnt, drain_cnt_next;

  // Next state
  always_comb begin
    state_next     = state;
    drain_cnt_next = drain_cnt;
    unique case (state)
      ST_IDLE: begin
        if (start_compute) begin
          if (sts.size_zero) begin
            state_next     = ST_DRAIN;
            drain_cnt_next = qap_pkg::DRAIN_LAST;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (sts.last_pair) begin
          state_next     = ST_DRAIN;
          drain_cnt_next = qap_pkg::DRAIN_LAST;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == '0) begin
          state_next = ST_DONE;
        end else begin
          drain_cnt_next = drain_cnt - 1'b1;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      drain_cnt <= '0;
    end else begin
      state     <= state_next;
      drain_cnt <= drain_cnt_next;
    end
  end

  // Commands and status outputs
  assign cmd.clear    = (state == ST_IDLE) && start_compute;
  assign cmd.step     = (state == ST_RUN);
  assign busy         = (state != ST_IDLE);
  assign result_valid = (state == ST_DONE);

  // Result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  // Busy only rises after a start
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start_compute))
    else $error("busy rose without a compute start");

  // Result only follows the drain
  a_done_after_drain: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == ST_DRAIN)
    else $error("result strobe without pipeline drain");

  // No pair issued outside a compute
  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> busy)
    else $error("pair issue ended without staying busy");

endmodule

@@ rtl/core/qap_dpath.sv @@
// Stores, pair counters and multiply-accumulate pipeline of the QAP cost evaluator.
`timescale 1ns / 1ps

module qap_dpath #(
  parameter int MAX_SIZE   = 32,
  parameter int VALUE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  qap_pkg::cmd_t                 cmd,
  output qap_pkg::sts_t                 sts,
  input  logic                          load_en,
  input  logic [1:0]                    kind,
  input  logic [qap_pkg::INDEX_W-1:0]   row_index,
  input  logic [qap_pkg::INDEX_W-1:0]   col_index,
  input  logic [qap_pkg::ENTRY_W-1:0]   entry_value,
  input  logic [qap_pkg::COST_W-1:0]    expected_cost,
  input  logic [qap_pkg::SIZE_W-1:0]    problem_size,
  output logic [qap_pkg::COST_W-1:0]    total_cost,
  output logic                          cost_matches,
  output logic                          bad_permutation
);

  localparam int IDX_W  = $clog2(MAX_SIZE);
  localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PROD_W = 2 * VALUE_BITS;
  localparam int SUM_W  = ((PROD_W > qap_pkg::COST_W) ? PROD_W : qap_pkg::COST_W) + 1;
  localparam int CMP_W  = (IDX_W > qap_pkg::SIZE_W) ? IDX_W : qap_pkg::SIZE_W;

  // Stores
  logic [VALUE_BITS-1:0]     flow_mem [DEPTH];
  logic [VALUE_BITS-1:0]     dist_mem [DEPTH];
  logic [qap_pkg::PERM_W-1:0] perm_mem [MAX_SIZE];

  // Load decode
  logic                       row_ok, col_ok;
  logic [ADDR_W-1:0]          wr_addr;
  logic [VALUE_BITS-1:0]      wr_val;
  logic [31:0]                wr_val32;
  logic [qap_pkg::PERM_W-1:0] perm_in;

  assign row_ok   = int'(row_index) < MAX_SIZE;
  assign col_ok   = int'(col_index) < MAX_SIZE;
  assign wr_addr  = ADDR_W'(int'(row_index) * MAX_SIZE + int'(col_index));
  assign wr_val   = VALUE_BITS'(entry_value);
  assign wr_val32 = 32'(wr_val);
  assign perm_in  = (wr_val32 > 32'(qap_pkg::PERM_SAT)) ? qap_pkg::PERM_SAT :
                    qap_pkg::PERM_W'(wr_val32);

  // Effective size n, latched at start
  logic [qap_pkg::SIZE_W-1:0] n_eff, n_q;
  logic [qap_pkg::COST_W-1:0] exp_q;
  logic [CMP_W-1:0]           n_last;

  assign n_eff  = (int'(problem_size) > MAX_SIZE) ? qap_pkg::SIZE_W'(MAX_SIZE) : problem_size;
  assign n_last = CMP_W'(n_q) - 1'b1;

  // Pair counters
  logic [IDX_W-1:0] i_cnt, j_cnt;
  logic             j_wrap;

  assign j_wrap         = (CMP_W'(j_cnt) == n_last);
  assign sts.last_pair  = j_wrap && (CMP_W'(i_cnt) == n_last);
  assign sts.size_zero  = (problem_size == '0);

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      i_cnt <= '0;
      j_cnt <= '0;
      n_q   <= n_eff;
      exp_q <= expected_cost;
    end else if (cmd.step) begin
      if (j_wrap) begin
        j_cnt <= '0;
        i_cnt <= i_cnt + 1'b1;
      end else begin
        j_cnt <= j_cnt + 1'b1;
      end
    end
  end

  // Stage 0: permutation store, two read ports
  logic [qap_pkg::PERM_W-1:0] pi_q, pj_q;
  logic [IDX_W-1:0]           s1_i, s1_j;
  logic                       s1_valid, s1_first;

  always_ff @(posedge clk) begin
    if (load_en && kind == qap_pkg::KIND_PERM && row_ok) begin
      perm_mem[IDX_W'(row_index)] <= perm_in;
    end
    pi_q <= perm_mem[i_cnt];
    pj_q <= perm_mem[j_cnt];
  end

  always_ff @(posedge clk) begin
    s1_i     <= i_cnt;
    s1_j     <= j_cnt;
    s1_first <= (i_cnt == '0);
  end

  // Stage 1: range check and matrix addresses
  logic [qap_pkg::PERM_W-1:0] n_perm;
  logic                       bad_i, bad_j;
  logic [IDX_W-1:0]           fac_row, fac_col;
  logic [ADDR_W-1:0]          flow_ra, dist_ra;
  logic [VALUE_BITS-1:0]      flow_q, dist_q;
  logic                       s2_valid, s2_skip, bad_q;

  assign n_perm  = qap_pkg::PERM_W'(n_q);
  assign bad_i   = (pi_q == '0) || (pi_q > n_perm);
  assign bad_j   = (pj_q == '0) || (pj_q > n_perm);
  assign fac_row = bad_i ? '0 : IDX_W'(pi_q - 1'b1);
  assign fac_col = bad_j ? '0 : IDX_W'(pj_q - 1'b1);
  assign flow_ra = ADDR_W'(int'(fac_row) * MAX_SIZE + int'(fac_col));
  assign dist_ra = ADDR_W'(int'(s1_i) * MAX_SIZE + int'(s1_j));

  always_ff @(posedge clk) begin
    if (load_en && kind == qap_pkg::KIND_FLOW && row_ok && col_ok) begin
      flow_mem[wr_addr] <= wr_val;
    end
    flow_q <= flow_mem[flow_ra];
  end

  always_ff @(posedge clk) begin
    if (load_en && kind == qap_pkg::KIND_DIST && row_ok && col_ok) begin
      dist_mem[wr_addr] <= wr_val;
    end
    dist_q <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk) begin
    s2_skip <= bad_i || bad_j || (s1_i == s1_j);
  end

  // Bad-entry flag: the first row visits every position j once
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      bad_q <= 1'b0;
    end else if (s1_valid && s1_first && bad_j) begin
      bad_q <= 1'b1;
    end
  end

  // Stage 2: multiply
  logic [PROD_W-1:0] prod_q;
  logic              s3_valid;

  always_ff @(posedge clk) begin
    prod_q <= s2_skip ? '0 : PROD_W'(flow_q) * PROD_W'(dist_q);
  end

  // Stage 3: saturating accumulate
  logic [qap_pkg::COST_W-1:0] acc;
  logic [SUM_W-1:0]           sum;
  localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'({qap_pkg::COST_W{1'b1}});

  assign sum = SUM_W'(acc) + SUM_W'(prod_q);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      acc <= '0;
    end else if (s3_valid) begin
      acc <= (sum > SUM_CAP) ? {qap_pkg::COST_W{1'b1}} : qap_pkg::COST_W'(sum);
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.step;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Result word
  assign total_cost      = acc;
  assign cost_matches    = (acc == exp_q);
  assign bad_permutation = bad_q;

  // A pair leaves stage 1 only after it was issued
  a_s1_follows_step: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(cmd.step))
    else $error("stage 1 valid without an issued pair");

  // Accumulator only moves when a product arrives or on clear
  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(s3_valid) && !$past(cmd.clear) |-> $stable(acc))
    else $error("accumulator changed without a product");

  // Accumulation never decreases within a compute
  a_acc_monotonic: assert property (@(posedge clk) disable iff (rst)
    $past(s3_valid) && !$past(cmd.clear) |-> acc >= $past(acc))
    else $error("accumulator decreased");

endmodule

@@ rtl/core/qap_assignment_cost.sv @@
// Top level of the QAP cost evaluator: config register, controller and datapath.
`timescale 1ns / 1ps
//
// Channel   | Handshake                   | Word
// ----------+-----------------------------+--------------------------------------------
// input     | start, busy                 | kind, row_index, col_index, entry_value,
//           |                             | expected_cost
// result    | result_valid (1-cycle)      | total_cost, cost_matches, bad_permutation
// config    | psel, penable, pwrite, ...  | problem_size at address 0
//
// Load words (flow, distance, permutation) are taken one per cycle while busy is low
// and leave it low. A compute word walks n*n position pairs, one per cycle, through a
// four-stage read / multiply / accumulate pipeline; result_valid strobes once it has
// drained, and busy drops in the cycle after (n = min(problem_size, MAX_SIZE)).
// Reset returns the sequencer to idle and problem_size to 32; stores are not cleared.
// The receiver cannot stall; the result words hold until the next compute starts.

module qap_assignment_cost #(
  parameter int MAX_SIZE   = 32,
  parameter int VALUE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // Input items
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind,
  input  logic [qap_pkg::INDEX_W-1:0] row_index,
  input  logic [qap_pkg::INDEX_W-1:0] col_index,
  input  logic [qap_pkg::ENTRY_W-1:0] entry_value,
  input  logic [qap_pkg::COST_W-1:0]  expected_cost,
  // Results
  output logic                        result_valid,
  output logic [qap_pkg::COST_W-1:0]  total_cost,
  output logic                        cost_matches,
  output logic                        bad_permutation,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // Configuration register
  logic [qap_pkg::SIZE_W-1:0] problem_size;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      problem_size <= qap_pkg::SIZE_RESET;
    end else if (cfg_wr && paddr[2] == qap_pkg::REG_PROBLEM_SIZE) begin
      problem_size <= pwdata[qap_pkg::SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == qap_pkg::REG_PROBLEM_SIZE) ? 32'(problem_size) : '0;

  // Item accept
  logic start_compute, load_en;

  assign start_compute = start && !busy && (kind == qap_pkg::KIND_COMPUTE);
  assign load_en       = start && !busy && (kind != qap_pkg::KIND_COMPUTE);

  qap_pkg::cmd_t cmd;
  qap_pkg::sts_t sts;

  qap_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start_compute (start_compute),
    .sts           (sts),
    .cmd           (cmd),
    .busy          (busy),
    .result_valid  (result_valid)
  );

  qap_dpath #(
    .MAX_SIZE   (MAX_SIZE),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .load_en         (load_en),
    .kind            (kind),
    .row_index       (row_index),
    .col_index       (col_index),
    .entry_value     (entry_value),
    .expected_cost   (expected_cost),
    .problem_size    (problem_size),
    .total_cost      (total_cost),
    .cost_matches    (cost_matches),
    .bad_permutation (bad_permutation)
  );

endmodule
